// File: rtl/core/dpc_pkg.sv
// ----------------------------------------------------------------------------
// dpc_pkg: shared types and constants for raw defect pixel correction
// Register indexes, default sizes and the result tag carried down the pipe.
// ----------------------------------------------------------------------------
`default_nettype none

package dpc_pkg;

    localparam int DATA_W        = 16;     // width of one channel field
    localparam int LANES         = 4;      // channel fields per pixel
    localparam int PIX_W         = DATA_W * LANES;
    localparam int POS_W         = 12;     // width of out_row / out_col
    localparam int MAX_HEIGHT    = 4096;
    localparam int SIZE_W        = 13;     // width of the size field in cfg_data
    localparam int CFG_W         = 16;     // widest register
    localparam int CFG_IDX_W     = 2;

    localparam int MAX_WIDTH_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CHANNELS_DEF    = 4;

    // Neighbor slots: 0 tl, 1 t, 2 tr, 3 l, 4 r, 5 bl, 6 b, 7 br.
    // Directional pairs: vertical, horizontal, diagonal right, diagonal left.
    localparam int PAIR_A [4] = '{1, 3, 0, 2};
    localparam int PAIR_B [4] = '{6, 4, 7, 5};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_THRESH = 2'd2,
        REG_MODE   = 2'd3
    } dpc_reg_t;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } dpc_tag_t;

endpackage

`default_nettype wire

// File: rtl/core/dpc_linebuf.sv
// ----------------------------------------------------------------------------
// dpc_linebuf: line store memory
// One entry per column holds the two previous rows; registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dpc_linebuf #(
    parameter int DEPTH = dpc_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = 2 * dpc_pkg::PIX_W
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/dpc_lane.sv
// ----------------------------------------------------------------------------
// dpc_lane: per-channel defect test and repair
// Stage one judges the sample and forms sums and gradients; the registered
// results are reduced to the repair value combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module dpc_lane #(
    parameter int SB = dpc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        load,
    input  wire logic [dpc_pkg::DATA_W-1:0]  thresh,
    input  wire logic                        mode,
    input  wire logic [SB-1:0]               ctr,
    input  wire logic [7:0][SB-1:0]          nb,
    output logic      [SB-1:0]               fix,
    output logic                             bad
);

    logic [7:0]          close;
    logic [SB+1:0]       sum4;
    logic [SB:0]         twoc;
    logic [3:0][SB:0]    psum;
    logic [3:0][SB:0]    grad;

    logic                bad_reg;
    logic                mode_reg;
    logic [SB-1:0]       mean4_reg;
    logic [3:0][SB:0]    psum_reg;
    logic [3:0][SB:0]    grad_reg;

    logic [1:0]          m01;
    logic [1:0]          m23;
    logic [1:0]          best;
    logic [SB+1:0]       pround;

    // Neighbor closeness: any close neighbor clears the defect.
    for (genvar i = 0; i < 8; i++)
    begin : g_close
        logic [SB-1:0] diff;
        assign diff     = (nb[i] > ctr) ? (nb[i] - ctr) : (ctr - nb[i]);
        assign close[i] = (dpc_pkg::DATA_W'(diff) <= thresh);
    end

    assign sum4 = (SB+2)'(nb[1]) + (SB+2)'(nb[3]) + (SB+2)'(nb[4]) + (SB+2)'(nb[6]);
    assign twoc = {ctr, 1'b0};

    for (genvar p = 0; p < 4; p++)
    begin : g_pair
        assign psum[p] = (SB+1)'(nb[dpc_pkg::PAIR_A[p]]) + (SB+1)'(nb[dpc_pkg::PAIR_B[p]]);
        assign grad[p] = (twoc > psum[p]) ? (twoc - psum[p]) : (psum[p] - twoc);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bad_reg   <= ~|close;
            mode_reg  <= mode;
            mean4_reg <= sum4[SB+1:2];
            psum_reg  <= psum;
            grad_reg  <= grad;
        end
    end

    // First minimum wins: earlier pair inside each half, then the first half.
    always_comb
    begin
        m01  = (grad_reg[1] < grad_reg[0]) ? 2'd1 : 2'd0;
        m23  = (grad_reg[3] < grad_reg[2]) ? 2'd3 : 2'd2;
        best = (grad_reg[m23] < grad_reg[m01]) ? m23 : m01;
    end

    assign pround = (SB+2)'(psum_reg[best]) + (SB+2)'(1);
    assign fix    = mode_reg ? pround[SB:1] : mean4_reg;
    assign bad    = bad_reg;

endmodule

`default_nettype wire

// File: rtl/core/raw_defect_pixel_correction.sv
// ----------------------------------------------------------------------------
// raw_defect_pixel_correction: 3x3 defect pixel correction, four channels
// Raster pixels in, corrected pixels out, mirrored window edges.
// ----------------------------------------------------------------------------
//
//  port group   dir   handshake             payload
//  ----------   ---   -------------------   -------------------------------------
//  cfg          in    cfg_we (no wait)      cfg_index, cfg_data
//  in           in    in_valid / in_ready   sample_ch0..3
//  out          out   out_valid / out_ready fixed_ch0..3, defect_mask, out_row,
//                                           out_col, frame_last
//
//  One pixel enters per cycle unless issue or output stalls. A pixel that
//  completes two or four results (last column, last row) holds job issue
//  until all have issued, so the last row is slower. A pixel passes the
//  capture, window, lane and output registers. Reset clears control and
//  the window; the line stores need no clearing. A stalled output holds
//  its transaction while upstream stages keep filling until each is occupied.
//
`default_nettype none

module raw_defect_pixel_correction #(
    parameter int MAX_WIDTH   = dpc_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = dpc_pkg::SAMPLE_BITS_DEF,
    parameter int CHANNELS    = dpc_pkg::CHANNELS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [dpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dpc_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [dpc_pkg::DATA_W-1:0]     sample_ch0,
    input  wire logic [dpc_pkg::DATA_W-1:0]     sample_ch1,
    input  wire logic [dpc_pkg::DATA_W-1:0]     sample_ch2,
    input  wire logic [dpc_pkg::DATA_W-1:0]     sample_ch3,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [dpc_pkg::DATA_W-1:0]     fixed_ch0,
    output logic      [dpc_pkg::DATA_W-1:0]     fixed_ch1,
    output logic      [dpc_pkg::DATA_W-1:0]     fixed_ch2,
    output logic      [dpc_pkg::DATA_W-1:0]     fixed_ch3,
    output logic      [dpc_pkg::LANES-1:0]      defect_mask,
    output logic      [dpc_pkg::POS_W-1:0]      out_row,
    output logic      [dpc_pkg::POS_W-1:0]      out_col,
    output logic                                frame_last
);

    localparam int CW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int DW  = dpc_pkg::DATA_W;
    localparam int PW  = dpc_pkg::PIX_W;
    localparam int RW  = dpc_pkg::POS_W;
    localparam int NL  = dpc_pkg::LANES;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CW-1:0]  wlast_reg;
    logic [RW-1:0]  hlast_reg;
    logic [DW-1:0]  thresh_reg;
    logic           mode_reg;
    logic [31:0]    wv;
    logic [31:0]    wc;
    logic [31:0]    hv;
    logic [31:0]    hc;
    logic [CW-1:0]  wlast_next;
    logic [RW-1:0]  hlast_next;
    logic           size_wr;

    always_comb
    begin
        wv = 32'(cfg_data[dpc_pkg::SIZE_W-1:0]);
        hv = 32'(cfg_data[dpc_pkg::SIZE_W-1:0]);
        priority if (wv < 32'd2)
            wc = 32'd2;
        else if (wv > 32'(MAX_WIDTH))
            wc = 32'(MAX_WIDTH);
        else
            wc = wv;
        priority if (hv < 32'd2)
            hc = 32'd2;
        else if (hv > 32'(dpc_pkg::MAX_HEIGHT))
            hc = 32'(dpc_pkg::MAX_HEIGHT);
        else
            hc = hv;
        wlast_next = CW'(wc - 32'd1);
        hlast_next = RW'(hc - 32'd1);
    end

    assign size_wr = cfg_we &&
                     ((dpc_pkg::dpc_reg_t'(cfg_index) == dpc_pkg::REG_WIDTH) ||
                      (dpc_pkg::dpc_reg_t'(cfg_index) == dpc_pkg::REG_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlast_reg  <= CW'(MAX_WIDTH - 1);
            hlast_reg  <= RW'(dpc_pkg::MAX_HEIGHT - 1);
            thresh_reg <= '0;
            mode_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (dpc_pkg::dpc_reg_t'(cfg_index))
                dpc_pkg::REG_WIDTH:  wlast_reg  <= wlast_next;
                dpc_pkg::REG_HEIGHT: hlast_reg  <= hlast_next;
                dpc_pkg::REG_THRESH: thresh_reg <= cfg_data[DW-1:0];
                dpc_pkg::REG_MODE:   mode_reg   <= cfg_data[0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Raster position and input capture
    // ------------------------------------------------------------------
    logic [CW-1:0]  col_reg;
    logic [RW-1:0]  row_reg;
    logic           in_xfer;
    logic           cur_lc;
    logic           cur_lr;
    logic [PW-1:0]  cur_pix;

    logic           a_valid_reg;
    logic [PW-1:0]  a_cur_reg;
    logic [CW-1:0]  a_c_reg;
    logic [RW-1:0]  a_r_reg;
    logic           a_lc_reg;
    logic           a_lr_reg;
    logic           a_to_b;

    logic [2*PW-1:0] ls_rd;
    logic [PW-1:0]   ls_up;
    logic [PW-1:0]   ls_lo;

    assign in_xfer = in_valid && in_ready;
    assign cur_lc  = (col_reg == wlast_reg);
    assign cur_lr  = (row_reg == hlast_reg);

    // Keep only the low SAMPLE_BITS of every channel.
    assign cur_pix = {DW'(sample_ch3[SAMPLE_BITS-1:0]), DW'(sample_ch2[SAMPLE_BITS-1:0]),
                      DW'(sample_ch1[SAMPLE_BITS-1:0]), DW'(sample_ch0[SAMPLE_BITS-1:0])};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (size_wr)
        begin
            // restart the frame
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_xfer)
        begin
            if (cur_lc)
            begin
                col_reg <= '0;
                row_reg <= cur_lr ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_to_b)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            a_cur_reg <= cur_pix;
            a_c_reg   <= col_reg;
            a_r_reg   <= row_reg;
            a_lc_reg  <= cur_lc;
            a_lr_reg  <= cur_lr;
        end
    end

    assign in_ready = !a_valid_reg || a_to_b;

    // Each entry holds {row r-2, row r-1} of its column; read on accept,
    // rewrite with {row r-1, row r} when the pixel moves into the window.
    dpc_linebuf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (2 * PW)
    ) u_linebuf (
        .clk     (clk),
        .rd_en   (in_xfer),
        .rd_addr (col_reg),
        .rd_data (ls_rd),
        .wr_en   (a_to_b),
        .wr_addr (a_c_reg),
        .wr_data ({ls_lo, a_cur_reg})
    );

    assign ls_up = ls_rd[2*PW-1:PW];
    assign ls_lo = ls_rd[PW-1:0];

    // ------------------------------------------------------------------
    // Window and job issue
    // ------------------------------------------------------------------
    // win_reg[row][col]: row 0 = r-2, 1 = r-1, 2 = r; col 2 is newest.
    logic [2:0][2:0][PW-1:0] win_reg;
    logic [3:0]              b_jobs_reg;
    logic [CW-1:0]           b_c_reg;
    logic [RW-1:0]           b_r_reg;
    logic                    b_top_reg;
    logic                    b_lft_reg;
    logic [3:0]              jobs_new;
    logic [3:0]              job_low;
    logic [3:0]              jobs_left;
    logic [1:0]              sel;
    logic                    issue;
    logic                    b_free;
    logic                    s1_free;

    always_comb
    begin
        jobs_new[0] = (a_r_reg != '0) && (a_c_reg != '0);
        jobs_new[1] = (a_r_reg != '0) && a_lc_reg;
        jobs_new[2] = a_lr_reg && (a_c_reg != '0);
        jobs_new[3] = a_lr_reg && a_lc_reg;
    end

    assign job_low   = b_jobs_reg & (~b_jobs_reg + 4'd1);
    assign jobs_left = b_jobs_reg & ~job_low;
    assign issue     = (b_jobs_reg != '0) && s1_free;
    assign b_free    = (b_jobs_reg == '0) || (issue && (jobs_left == '0));
    assign a_to_b    = a_valid_reg && b_free;

    always_comb
    begin
        priority if (b_jobs_reg[0])
            sel = 2'd0;
        else if (b_jobs_reg[1])
            sel = 2'd1;
        else if (b_jobs_reg[2])
            sel = 2'd2;
        else
            sel = 2'd3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= '0;
            b_jobs_reg <= '0;
        end
        else if (a_to_b)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= ls_up;
            win_reg[1][2] <= ls_lo;
            win_reg[2][2] <= a_cur_reg;
            b_jobs_reg    <= jobs_new;
        end
        else if (issue)
        begin
            b_jobs_reg <= jobs_left;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_to_b)
        begin
            b_c_reg   <= a_c_reg;
            b_r_reg   <= a_r_reg;
            b_top_reg <= (a_r_reg == RW'(1));
            b_lft_reg <= (a_c_reg == CW'(1));
        end
    end

    // Jobs 0/1 describe row r-1, jobs 2/3 row r (bottom mirrored to r-1).
    // Jobs 0/2 describe column c-1, jobs 1/3 column c (right mirrored).
    logic                 row_a;
    logic                 col_a;
    logic [2:0][PW-1:0]   rt;
    logic [2:0][PW-1:0]   rm;
    logic [2:0][PW-1:0]   rb;
    logic [8:0][PW-1:0]   px;   // tl t tr l c r bl b br
    dpc_pkg::dpc_tag_t    tag;

    assign row_a = ~sel[1];
    assign col_a = ~sel[0];

    always_comb
    begin
        rt = row_a ? (b_top_reg ? win_reg[2] : win_reg[0]) : win_reg[1];
        rm = row_a ? win_reg[1] : win_reg[2];
        rb = row_a ? win_reg[2] : win_reg[1];
        px[0] = col_a ? (b_lft_reg ? rt[2] : rt[0]) : rt[1];
        px[1] = col_a ? rt[1] : rt[2];
        px[2] = col_a ? rt[2] : rt[1];
        px[3] = col_a ? (b_lft_reg ? rm[2] : rm[0]) : rm[1];
        px[4] = col_a ? rm[1] : rm[2];
        px[5] = col_a ? rm[2] : rm[1];
        px[6] = col_a ? (b_lft_reg ? rb[2] : rb[0]) : rb[1];
        px[7] = col_a ? rb[1] : rb[2];
        px[8] = col_a ? rb[2] : rb[1];
    end

    always_comb
    begin
        tag.row  = sel[1] ? b_r_reg : (b_r_reg - RW'(1));
        tag.col  = RW'(sel[0] ? b_c_reg : (b_c_reg - CW'(1)));
        tag.last = (sel == 2'd3);
    end

    // ------------------------------------------------------------------
    // Lanes
    // ------------------------------------------------------------------
    logic                       s1_valid_reg;
    dpc_pkg::dpc_tag_t          s1_tag_reg;
    logic [NL-1:0][DW-1:0]      s1_ctr_reg;
    logic                       o_free;
    logic                       s1_to_o;
    logic [NL-1:0][DW-1:0]      lane_fix;
    logic [NL-1:0]              lane_bad;

    assign o_free  = !out_valid || out_ready;
    assign s1_to_o = s1_valid_reg && o_free;
    assign s1_free = !s1_valid_reg || o_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (issue)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_to_o)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    for (genvar k = 0; k < NL; k++)
    begin : g_lane
        if (k < CHANNELS)
        begin : g_core
            logic [7:0][SAMPLE_BITS-1:0] nbk;
            logic [SAMPLE_BITS-1:0]      fixk;

            assign nbk[0] = px[0][DW*k +: SAMPLE_BITS];
            assign nbk[1] = px[1][DW*k +: SAMPLE_BITS];
            assign nbk[2] = px[2][DW*k +: SAMPLE_BITS];
            assign nbk[3] = px[3][DW*k +: SAMPLE_BITS];
            assign nbk[4] = px[5][DW*k +: SAMPLE_BITS];
            assign nbk[5] = px[6][DW*k +: SAMPLE_BITS];
            assign nbk[6] = px[7][DW*k +: SAMPLE_BITS];
            assign nbk[7] = px[8][DW*k +: SAMPLE_BITS];

            dpc_lane #(
                .SB (SAMPLE_BITS)
            ) u_lane (
                .clk    (clk),
                .load   (issue),
                .thresh (thresh_reg),
                .mode   (mode_reg),
                .ctr    (px[4][DW*k +: SAMPLE_BITS]),
                .nb     (nbk),
                .fix    (fixk),
                .bad    (lane_bad[k])
            );

            assign lane_fix[k] = DW'(fixk);
        end
        else
        begin : g_pass
            // unused channel: pass through, never flagged
            assign lane_fix[k] = s1_ctr_reg[k];
            assign lane_bad[k] = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                   out_valid_reg;
    logic [NL-1:0][DW-1:0]  fixed_reg;
    logic [NL-1:0]          mask_reg;
    dpc_pkg::dpc_tag_t      out_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_to_o)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_to_o)
        begin
            for (int k = 0; k < NL; k++)
            begin
                fixed_reg[k] <= lane_bad[k] ? lane_fix[k] : s1_ctr_reg[k];
            end
            mask_reg    <= lane_bad;
            out_tag_reg <= s1_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_tag_reg <= tag;
            for (int k = 0; k < NL; k++)
            begin
                s1_ctr_reg[k] <= px[4][DW*k +: DW];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign fixed_ch0   = fixed_reg[0];
    assign fixed_ch1   = fixed_reg[1];
    assign fixed_ch2   = fixed_reg[2];
    assign fixed_ch3   = fixed_reg[3];
    assign defect_mask = mask_reg;
    assign out_row     = out_tag_reg.row;
    assign out_col     = out_tag_reg.col;
    assign frame_last  = out_tag_reg.last;

endmodule

`default_nettype wire

// File: rtl/core/dpc_checker.sv
// ----------------------------------------------------------------------------
// dpc_checker: port-level checks for raw defect pixel correction
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dpc_checker #(
    parameter int CHANNELS = dpc_pkg::CHANNELS_DEF
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [dpc_pkg::DATA_W-1:0]    fixed_ch0,
    input wire logic [dpc_pkg::LANES-1:0]     defect_mask,
    input wire logic [dpc_pkg::POS_W-1:0]     out_row,
    input wire logic [dpc_pkg::POS_W-1:0]     out_col,
    input wire logic                          frame_last
);

    // hold a stalled transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fixed_ch0) &&
        $stable(out_row) && $stable(out_col) && $stable(defect_mask))
        else $error("stalled result changed");

    a_mask_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((defect_mask >> CHANNELS) == '0))
        else $error("defect flagged on an unused channel");

    // frames have at least two rows
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_last |-> (out_row != '0))
        else $error("frame end on the first row");

    // the result after a frame end opens the next frame
    a_next_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && frame_last |=>
        !out_valid || ((out_row == '0) && (out_col == '0)))
        else $error("result after frame end is not the frame origin");

endmodule

bind raw_defect_pixel_correction dpc_checker #(
    .CHANNELS (CHANNELS)
) u_dpc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .fixed_ch0   (fixed_ch0),
    .defect_mask (defect_mask),
    .out_row     (out_row),
    .out_col     (out_col),
    .frame_last  (frame_last)
);

`default_nettype wire
